@@ rtl/taylor_series_sine_core_macros.svh @@
// concurrent check helpers shared by the rtl files
`ifndef TAYLOR_SERIES_SINE_CORE_MACROS_SVH
`define TAYLOR_SERIES_SINE_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tss_pkg.sv @@
package tss_pkg;

    localparam int TERM_COUNT = 10;
    localparam int FRAC_BITS  = 28;
    localparam int ANGLE_W    = 32;
    localparam int ACC_W      = 48;
    localparam int MAG_W      = ACC_W - 1;
    // x*x shifted down, always below the 48-bit magnitude cap
    localparam int SQ_W       = 2 * ANGLE_W - 1 - FRAC_BITS;
    localparam int TP_W       = MAG_W + SQ_W;
    localparam int QW         = TP_W - FRAC_BITS;
    localparam int D_MAX      = (2 * (TERM_COUNT - 1)) * (2 * (TERM_COUNT - 1) + 1);
    localparam int L_MAX      = $clog2(D_MAX);
    // dividend width that still yields a quotient below the cap
    localparam int QN_W       = MAG_W + L_MAX;
    localparam int RCP_W      = QN_W + 1;
    localparam int PROD_W     = QN_W + RCP_W;
    localparam int SH_W       = $clog2(PROD_W);
    localparam int T_LO_W     = (MAG_W + 1) / 2;
    localparam int T_HI_W     = MAG_W - T_LO_W;
    localparam int Q_LO_W     = (QN_W + 1) / 2;
    localparam int Q_HI_W     = QN_W - Q_LO_W;
    localparam int R_LO_W     = (RCP_W + 1) / 2;
    localparam int R_HI_W     = RCP_W - R_LO_W;

    typedef logic [RCP_W-1:0] t_recip;
    typedef logic [SH_W-1:0]  t_shift;

    typedef struct packed {
        logic                    vld;
        logic                    tneg;
        logic signed [ACC_W-1:0] acc;
        logic [MAG_W-1:0]        tmag;
        logic [SQ_W-1:0]         sq;
    } t_lane;

    // running sum plus a sign/magnitude term, saturated to 48 bits
    function automatic logic signed [ACC_W-1:0] acc_add(
        input logic signed [ACC_W-1:0] acc,
        input logic [MAG_W-1:0]        mag,
        input logic                    neg
    );
        logic [ACC_W:0] term;
        logic [ACC_W:0] s;
        term = neg ? (~{2'b00, mag} + 1'b1) : {2'b00, mag};
        s    = {acc[ACC_W-1], acc} + term;
        if (s[ACC_W] != s[ACC_W-1]) begin
            acc_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_add = s[ACC_W-1:0];
        end
    endfunction

endpackage

@@ rtl/tss_angle_if.sv @@
interface tss_angle_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tss_pkg::ANGLE_W-1:0]   angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

@@ rtl/tss_sine_if.sv @@
interface tss_sine_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tss_pkg::ANGLE_W-1:0]   sine_value;

    modport source (output valid, output sine_value, input ready);
    modport sink   (input valid, input sine_value, output ready);
endinterface

@@ rtl/tss_prep.sv @@
module tss_prep (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_vld,
    input  logic signed [tss_pkg::ANGLE_W-1:0] i_angle,
    output tss_pkg::t_lane                     o_lane
);

    localparam int ANGLE_W = tss_pkg::ANGLE_W;
    localparam int MAG_W   = tss_pkg::MAG_W;

    logic [ANGLE_W-1:0]   n_ax;
    logic [2*ANGLE_W-1:0] n_sqp;

    logic                 r_vld;
    logic                 r_neg;
    logic [ANGLE_W-1:0]   r_ax;
    logic [2*ANGLE_W-1:0] r_sqp;

    // most negative angle maps to 2^31, still fits unsigned
    assign n_ax  = i_angle[ANGLE_W-1] ? (~i_angle + 1'b1) : i_angle;
    assign n_sqp = n_ax * n_ax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg <= i_angle[ANGLE_W-1];
            r_ax  <= n_ax;
            r_sqp <= n_sqp;
        end
    end

    always_comb begin
        o_lane.vld  = r_vld;
        o_lane.tneg = r_neg;
        o_lane.acc  = '0;
        o_lane.tmag = {{(MAG_W-ANGLE_W){1'b0}}, r_ax};
        o_lane.sq   = r_sqp[tss_pkg::FRAC_BITS +: tss_pkg::SQ_W];
    end

endmodule

@@ rtl/tss_term.sv @@
`include "taylor_series_sine_core_macros.svh"

module tss_term (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  tss_pkg::t_recip i_recip,
    input  tss_pkg::t_shift i_rshift,
    input  tss_pkg::t_lane  i_lane,
    output tss_pkg::t_lane  o_lane
);

    localparam int TP_W   = tss_pkg::TP_W;
    localparam int QN_W   = tss_pkg::QN_W;
    localparam int PROD_W = tss_pkg::PROD_W;
    localparam int MAG_W  = tss_pkg::MAG_W;
    localparam int FRAC   = tss_pkg::FRAC_BITS;
    localparam int T_LO_W = tss_pkg::T_LO_W;
    localparam int Q_LO_W = tss_pkg::Q_LO_W;
    localparam int R_LO_W = tss_pkg::R_LO_W;

    typedef struct packed {
        logic                                       vld;
        logic                                       tneg;
        logic signed [tss_pkg::ACC_W-1:0]           acc;
        logic [tss_pkg::SQ_W-1:0]                   sq;
        logic [tss_pkg::T_LO_W+tss_pkg::SQ_W-1:0]   pa;
        logic [tss_pkg::T_HI_W+tss_pkg::SQ_W-1:0]   pb;
    } t_stg_a;

    typedef struct packed {
        logic                                       vld;
        logic                                       tneg;
        logic signed [tss_pkg::ACC_W-1:0]           acc;
        logic [tss_pkg::SQ_W-1:0]                   sq;
        logic                                       ovf;
        logic [tss_pkg::QN_W-1:0]                   q;
    } t_stg_b;

    typedef struct packed {
        logic                                       vld;
        logic                                       tneg;
        logic signed [tss_pkg::ACC_W-1:0]           acc;
        logic [tss_pkg::SQ_W-1:0]                   sq;
        logic                                       ovf;
        logic [tss_pkg::Q_HI_W+tss_pkg::R_HI_W-1:0] pp_hh;
        logic [tss_pkg::Q_HI_W+tss_pkg::R_LO_W-1:0] pp_hl;
        logic [tss_pkg::Q_LO_W+tss_pkg::R_HI_W-1:0] pp_lh;
        logic [tss_pkg::Q_LO_W+tss_pkg::R_LO_W-1:0] pp_ll;
    } t_stg_c;

    t_stg_a         r_a, n_a;
    t_stg_b         r_b, n_b;
    t_stg_c         r_c, n_c;
    tss_pkg::t_lane r_d, n_d;

    logic [TP_W-1:0]   w_tp;
    logic [QN_W-1:0]   w_q;
    logic              w_ovf;
    logic [PROD_W-1:0] w_sum;
    logic [PROD_W-1:0] w_quo;

    // stage a: fold the previous term into the sum, split multiply term * x^2
    always_comb begin
        n_a.vld  = i_lane.vld;
        n_a.tneg = ~i_lane.tneg;
        n_a.acc  = tss_pkg::acc_add(i_lane.acc, i_lane.tmag, i_lane.tneg);
        n_a.sq   = i_lane.sq;
        n_a.pa   = i_lane.tmag[T_LO_W-1:0] * i_lane.sq;
        n_a.pb   = i_lane.tmag[MAG_W-1:T_LO_W] * i_lane.sq;
    end

    // stage b: join partial products and drop the fraction bits
    assign w_tp = TP_W'(r_a.pa) + (TP_W'(r_a.pb) << T_LO_W);

    generate
        if (tss_pkg::QW > QN_W) begin : g_wide
            assign w_q   = w_tp[FRAC +: QN_W];
            assign w_ovf = |w_tp[TP_W-1:FRAC+QN_W];
        end else begin : g_narrow
            assign w_q   = QN_W'(w_tp[TP_W-1:FRAC]);
            assign w_ovf = 1'b0;
        end
    endgenerate

    always_comb begin
        n_b.vld  = r_a.vld;
        n_b.tneg = r_a.tneg;
        n_b.acc  = r_a.acc;
        n_b.sq   = r_a.sq;
        n_b.ovf  = w_ovf;
        n_b.q    = w_q;
    end

    // stage c: divide by (2n)(2n+1) as a multiply by its reciprocal
    always_comb begin
        n_c.vld   = r_b.vld;
        n_c.tneg  = r_b.tneg;
        n_c.acc   = r_b.acc;
        n_c.sq    = r_b.sq;
        n_c.ovf   = r_b.ovf;
        n_c.pp_hh = r_b.q[QN_W-1:Q_LO_W] * i_recip[tss_pkg::RCP_W-1:R_LO_W];
        n_c.pp_hl = r_b.q[QN_W-1:Q_LO_W] * i_recip[R_LO_W-1:0];
        n_c.pp_lh = r_b.q[Q_LO_W-1:0] * i_recip[tss_pkg::RCP_W-1:R_LO_W];
        n_c.pp_ll = r_b.q[Q_LO_W-1:0] * i_recip[R_LO_W-1:0];
    end

    // stage d: quotient, capped at the largest 48-bit magnitude
    assign w_sum = PROD_W'(r_c.pp_ll)
                 + (PROD_W'(r_c.pp_lh) << R_LO_W)
                 + (PROD_W'(r_c.pp_hl) << Q_LO_W)
                 + (PROD_W'(r_c.pp_hh) << (Q_LO_W + R_LO_W));
    assign w_quo = w_sum >> i_rshift;

    always_comb begin
        n_d.vld  = r_c.vld;
        n_d.tneg = r_c.tneg;
        n_d.acc  = r_c.acc;
        n_d.sq   = r_c.sq;
        n_d.tmag = (r_c.ovf || (|w_quo[PROD_W-1:MAG_W])) ? '1 : w_quo[MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.vld <= 1'b0;
            r_b.vld <= 1'b0;
            r_c.vld <= 1'b0;
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
        end
    end

    assign o_lane = r_d;

    `TSS_ASSERT_NEXT(a_zero_pp, i_clk, i_rst_n, i_en && i_lane.vld && (i_lane.tmag == '0), (r_a.pa == '0) && (r_a.pb == '0), "zero term gave nonzero partial products")
    `TSS_ASSERT_NEXT(a_zero_acc, i_clk, i_rst_n, i_en && i_lane.vld && (i_lane.tmag == '0), r_a.acc == $past(i_lane.acc), "zero term changed the running sum")
    `TSS_ASSERT_NEXT(a_cap_mag, i_clk, i_rst_n, i_en && r_c.vld && r_c.ovf, r_d.tmag == '1, "oversized quotient not capped")

endmodule

@@ rtl/taylor_series_sine_core.sv @@
// channel   | direction | payload
// i_angle   | sink      | angle, signed, 28 fraction bits
// o_sine    | source    | sine_value, signed, 28 fraction bits, saturated
//
// one angle per cycle unless the pipeline holds; a taken request passes through
// one square stage, four stages per series term after the first, then the output register.
// the two multiplier stages and the reciprocal divide of each term set that depth.
// i_rst_n is synchronous and clears only the valid bits and the output count.
// a two-entry output buffer lets the pipeline run on while a result waits;
// when it is full and o_sine is not ready the whole pipeline holds.

`include "taylor_series_sine_core_macros.svh"

module taylor_series_sine_core (
    input logic        i_clk,
    input logic        i_rst_n,
    tss_angle_if.sink  i_angle,
    tss_sine_if.source o_sine
);

    localparam int TERM_COUNT = tss_pkg::TERM_COUNT;
    localparam int ANGLE_W    = tss_pkg::ANGLE_W;
    localparam int ACC_W      = tss_pkg::ACC_W;
    localparam int PROD_W     = tss_pkg::PROD_W;
    localparam int QN_W       = tss_pkg::QN_W;
    localparam int RCP_W      = tss_pkg::RCP_W;
    localparam int SH_W       = tss_pkg::SH_W;

    tss_pkg::t_lane            w_lane [TERM_COUNT];
    logic                      w_en;
    logic                      w_push;
    logic                      w_pop;
    logic signed [ACC_W-1:0]   n_acc;
    logic [ANGLE_W-1:0]        n_res;
    logic [1:0]                n_cnt;

    logic [1:0]                r_cnt;
    logic [ANGLE_W-1:0]        r_head;
    logic [ANGLE_W-1:0]        r_skid;

    assign w_en          = (r_cnt != 2'd2) || o_sine.ready;
    assign i_angle.ready = w_en;

    tss_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_angle.valid),
        .i_angle (i_angle.angle),
        .o_lane  (w_lane[0])
    );

    for (genvar k = 1; k < TERM_COUNT; k++) begin : g_term
        localparam int unsigned     DIV  = (2 * k) * (2 * k + 1);
        localparam int unsigned     LOG  = $clog2(DIV);
        localparam logic [PROD_W-1:0] POW = PROD_W'(1) << (QN_W + LOG);
        localparam logic [PROD_W-1:0] RCP = POW / PROD_W'(DIV) + PROD_W'(1);

        tss_term u_term (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_recip  (RCP[RCP_W-1:0]),
            .i_rshift (SH_W'(QN_W + LOG)),
            .i_lane   (w_lane[k-1]),
            .o_lane   (w_lane[k])
        );
    end

    // last term joins the sum, then clamp to 32 bits
    assign n_acc = tss_pkg::acc_add(w_lane[TERM_COUNT-1].acc, w_lane[TERM_COUNT-1].tmag,
                                    w_lane[TERM_COUNT-1].tneg);

    always_comb begin
        if ((&n_acc[ACC_W-1:ANGLE_W-1]) || !(|n_acc[ACC_W-1:ANGLE_W-1])) begin
            n_res = n_acc[ANGLE_W-1:0];
        end else if (n_acc[ACC_W-1]) begin
            n_res = {1'b1, {(ANGLE_W-1){1'b0}}};
        end else begin
            n_res = {1'b0, {(ANGLE_W-1){1'b1}}};
        end
    end

    assign w_push = w_en && w_lane[TERM_COUNT-1].vld;
    assign w_pop  = o_sine.valid && o_sine.ready;
    assign n_cnt  = r_cnt + {1'b0, w_push} - {1'b0, w_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_head <= (r_cnt == 2'd2) ? r_skid : n_res;
        end else if (r_cnt == 2'd0) begin
            r_head <= n_res;
        end
        if (w_push && (((r_cnt == 2'd1) && !w_pop) || ((r_cnt == 2'd2) && w_pop))) begin
            r_skid <= n_res;
        end
    end

    assign o_sine.valid      = (r_cnt != 2'd0);
    assign o_sine.sine_value = r_head;

    `TSS_ASSERT_SAME(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3, "output buffer count out of range")
    `TSS_ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, w_push, o_sine.valid, "finished request not offered")
    `TSS_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, w_pop && !w_push, r_cnt == ($past(r_cnt) - 2'd1), "taken result not removed")
    `TSS_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !w_en, $stable(w_lane[TERM_COUNT-1]), "pipeline moved while stalled")

endmodule

@@ test/tb_taylor_series_sine_core.sv @@
`timescale 1ns / 100ps

module tb_taylor_series_sine_core;

    localparam int             ANGLE_W        = tss_pkg::ANGLE_W;
    localparam int             ACC_W          = tss_pkg::ACC_W;
    localparam int             FRAC_BITS      = tss_pkg::FRAC_BITS;
    localparam int             TERM_COUNT     = tss_pkg::TERM_COUNT;
    localparam int             WATCHDOG_LIMIT = 1000;
    localparam int             DRAIN_CYCLES   = 60;
    localparam int             RANDOM_ANGLES  = 1900;
    localparam int             CHUNK          = 100;
    localparam logic [63:0]    MAG_CAP        = 64'h0000_7FFF_FFFF_FFFF;
    localparam longint         SUM_MAX        = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint         SUM_MIN        = -(longint'(1) <<< (ACC_W - 1));
    localparam longint         OUT_MAX        = 64'sh0000_0000_7FFF_FFFF;
    localparam longint         OUT_MIN        = -(longint'(1) <<< 31);
    localparam int             PI_Q28         = 843314857;
    localparam int             HALF_PI_Q28    = 421657428;

    typedef struct {
        logic signed [ANGLE_W-1:0] angle;
        logic signed [ANGLE_W-1:0] sine;
    } t_sine_expect;

    class sine_scoreboard;
        t_sine_expect pending_sines[$];
        int           mismatches;

        function new();
            mismatches = 0;
        endfunction

        // ten-term series with truncated magnitudes, 48-bit saturated sum
        function logic signed [ANGLE_W-1:0] series_sine(logic signed [ANGLE_W-1:0] angle);
            longint       x;
            longint       term;
            longint       sum;
            logic [63:0]  ax;
            logic [63:0]  sq;
            logic [63:0]  at;
            logic [63:0]  mag;
            logic [127:0] prod;
            logic [127:0] quot;
            int           d;
            x    = longint'(angle);
            ax   = (x < 0) ? -x : x;
            sq   = (ax * ax) >> FRAC_BITS;
            if (sq > MAG_CAP) sq = MAG_CAP;
            term = x;
            sum  = x;
            for (int n = 1; n < TERM_COUNT; n++) begin
                d    = (2 * n) * (2 * n + 1);
                at   = (term < 0) ? -term : term;
                prod = 128'(at) * 128'(sq);
                quot = (prod >> FRAC_BITS) / 128'(d);
                mag  = (quot > 128'(MAG_CAP)) ? MAG_CAP : quot[63:0];
                term = (term < 0) ? longint'(mag) : -longint'(mag);
                sum  = sum + term;
                if (sum > SUM_MAX) sum = SUM_MAX;
                if (sum < SUM_MIN) sum = SUM_MIN;
            end
            if (sum > OUT_MAX) sum = OUT_MAX;
            if (sum < OUT_MIN) sum = OUT_MIN;
            return sum[ANGLE_W-1:0];
        endfunction

        function void note_angle(logic signed [ANGLE_W-1:0] angle);
            t_sine_expect e;
            e.angle = angle;
            e.sine  = series_sine(angle);
            pending_sines.push_back(e);
        endfunction

        function void check_sine(logic signed [ANGLE_W-1:0] sine_value);
            t_sine_expect e;
            if (pending_sines.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: sine_value %0d with no request outstanding",
                             $time, sine_value);
                return;
            end
            e = pending_sines.pop_front();
            if (sine_value !== e.sine) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: angle %h: sine_value expected %h (%0d) got %h (%0d)",
                             $time, e.angle, e.sine, e.sine, sine_value, sine_value);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    tss_angle_if angle_ch();
    tss_sine_if  sine_ch();

    taylor_series_sine_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_angle (angle_ch),
        .o_sine  (sine_ch)
    );

    sine_scoreboard            sb;
    int                        src_gap_pct;
    int                        sink_stall_pct;
    logic signed [ANGLE_W-1:0] last_angle;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // both channels are sampled with pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n && angle_ch.valid && angle_ch.ready)
            sb.note_angle(angle_ch.angle);
        if (i_rst_n && sine_ch.valid && sine_ch.ready)
            sb.check_sine(sine_ch.sine_value);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((angle_ch.valid && angle_ch.ready) || (sine_ch.valid && sine_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : sine_sink
        int hold;
        hold          = 0;
        sine_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
                sine_ch.ready <= 1'b0;
                hold = $urandom_range(0, 2);
            end else begin
                sine_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_angle(input logic signed [ANGLE_W-1:0] angle);
        if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
            angle_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        angle_ch.valid <= 1'b1;
        angle_ch.angle <= angle;
        last_angle = angle;
        do @(posedge i_clk); while (!angle_ch.ready);
    endtask

    // hold the request side until every outstanding sine has come back
    task automatic wait_for_sines();
        angle_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_sines.size() != 0);
    endtask

    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        logic signed [ANGLE_W-1:0] a;
        case ($urandom_range(0, 9)) inside
            [0:3]: a = $urandom;
            [4:6]: a = int'($urandom_range(0, 2 * PI_Q28)) - PI_Q28;
            7:     a = $signed($urandom) >>> $urandom_range(8, 30);
            8: begin
                // |x| between 6 and 8, where the series terms grow largest
                a = $urandom_range(32'd6 << FRAC_BITS, 32'h7FFF_FFFF);
                if ($urandom_range(0, 1) != 0) a = -a;
            end
            default: begin
                // mirror image of the last angle, so odd-symmetric pairs reach the scoreboard
                a = (last_angle == 32'sh8000_0000) ? last_angle : -last_angle;
            end
        endcase
        return a;
    endfunction

    initial begin : stimulus
        int corners[$];
        int levels[4];
        corners = '{
            0, 1, -1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
            HALF_PI_Q28, -HALF_PI_Q28, PI_Q28, -PI_Q28, 2 * PI_Q28, -2 * PI_Q28,
            1 << FRAC_BITS, -(1 << FRAC_BITS), 2 << FRAC_BITS, 3 << FRAC_BITS,
            5 << FRAC_BITS, 7 << FRAC_BITS, -(7 << FRAC_BITS), 32'h5555_5555,
            32'hAAAA_AAAA, 32'h0001_0000, 32'h7000_0000, 32'h9000_0000
        };
        levels         = '{0, 10, 30, 60};
        sb             = new();
        i_rst_n        = 1'b0;
        angle_ch.valid = 1'b0;
        angle_ch.angle = '0;
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        last_angle     = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corners[k]) send_angle(corners[k]);
        wait_for_sines();

        for (int k = 0; k < RANDOM_ANGLES; k++) begin
            if (k % CHUNK == 0) begin
                if (k >= RANDOM_ANGLES - 2 * CHUNK) begin
                    src_gap_pct    = 0;
                    sink_stall_pct = 0;
                end else begin
                    src_gap_pct    = levels[$urandom_range(0, 3)];
                    sink_stall_pct = levels[$urandom_range(0, 3)];
                end
                if (k == 9 * CHUNK) wait_for_sines();
            end
            send_angle(pick_angle());
        end

        wait_for_sines();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_sines.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
